>>> rtl/core/cfpr_pkg.sv
// shared types, constants and the byte-wise crc function for the framed packet receiver
// no dependencies
package cfpr_pkg;

  // framing and crc constants
  localparam logic [7:0]  SYNC_FIRST  = 8'hC3;
  localparam logic [7:0]  SYNC_SECOND = 8'h3C;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_TOP     = 16'h8000;

  // default payload capacity in bytes
  localparam int DEF_MAX_PAYLOAD = 64;

  // configuration register indexes
  localparam logic CFG_EXPECTED_VERSION = 1'b0;
  localparam logic CFG_ACK_TYPE_CODE    = 1'b1;

  // frame status codes
  typedef enum logic [1:0] {
    ST_ACK      = 2'd0,
    ST_CRC_BAD  = 2'd1,
    ST_NOT_ACK  = 2'd2,
    ST_OVERSIZE = 2'd3
  } status_t;

  // one finished frame report
  typedef struct packed {
    status_t     status;
    logic [7:0]  type_seen;
    logic [15:0] sequence_no;
    logic [15:0] acked;
  } result_t;

  // crc-16/ccitt-false over one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/cfpr_in_reg.sv
// input register stage: holds one received byte until the parser takes it
// depends on nothing outside this file
module cfpr_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       step,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  // free when empty or when the held item moves on this cycle
  assign in_ready = !hold_valid || step;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // byte register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= rx_byte;
    end
  end

endmodule

>>> rtl/core/cfpr_parser.sv
// frame parser: phase machine, running crc, header capture and result build
// depends on cfpr_pkg
module cfpr_parser import cfpr_pkg::*; #(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       byte_valid,
  input  logic [7:0] byte_in,
  input  logic       step,
  output logic       has_result,
  output result_t    result
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  typedef enum logic [9:0] {
    PH_SYNC1 = 10'b00_0000_0001,
    PH_SYNC2 = 10'b00_0000_0010,
    PH_VER   = 10'b00_0000_0100,
    PH_TYPE  = 10'b00_0000_1000,
    PH_LEN   = 10'b00_0001_0000,
    PH_SEQL  = 10'b00_0010_0000,
    PH_SEQH  = 10'b00_0100_0000,
    PH_PAY   = 10'b00_1000_0000,
    PH_CRCL  = 10'b01_0000_0000,
    PH_CRCH  = 10'b10_0000_0000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  expected_version;
  logic [7:0]  ack_type_code;
  logic [15:0] running_crc;
  logic [7:0]  crc_low_byte;
  logic [7:0]  version_seen;
  logic [7:0]  type_seen;
  logic [7:0]  payload_length;
  logic [15:0] header_sequence;
  logic [7:0]  payload_count;
  logic [15:0] first_payload_word;

  logic [15:0] crc_upd;
  logic [7:0]  count_inc;
  logic [15:0] crc_got;
  logic        oversize;
  status_t     end_status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 8'd1;
      ack_type_code    <= 8'd2;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_EXPECTED_VERSION: expected_version <= cfg_data;
        CFG_ACK_TYPE_CODE:    ack_type_code    <= cfg_data;
        default:              ;
      endcase
    end
  end

  // per-byte datapath terms
  assign crc_upd   = crc_byte(running_crc, byte_in);
  assign count_inc = payload_count + 8'd1;
  assign crc_got   = {byte_in, crc_low_byte};
  assign oversize  = byte_in > MaxLen;

  // status at the closing crc byte
  always_comb begin
    if (crc_got != running_crc) begin
      end_status = ST_CRC_BAD;
    end else if (version_seen == expected_version && type_seen == ack_type_code &&
                 payload_length == 8'd2) begin
      end_status = ST_ACK;
    end else begin
      end_status = ST_NOT_ACK;
    end
  end

  // result for the byte now held
  always_comb begin
    has_result         = 1'b0;
    result.status      = end_status;
    result.type_seen   = type_seen;
    result.sequence_no = header_sequence;
    result.acked       = (end_status == ST_ACK) ? first_payload_word : 16'h0000;
    if (byte_valid && phase == PH_LEN && oversize) begin
      has_result         = 1'b1;
      result.status      = ST_OVERSIZE;
      result.sequence_no = 16'h0000;
      result.acked       = 16'h0000;
    end else if (byte_valid && phase == PH_CRCH) begin
      has_result = 1'b1;
    end
  end

  // phase sequencing
  always_comb begin
    phase_next = PH_SYNC1;
    unique case (phase)
      PH_SYNC2: begin
        if (byte_in == SYNC_SECOND) begin
          phase_next = PH_VER;
        end else if (byte_in == SYNC_FIRST) begin
          phase_next = PH_SYNC2;
        end
      end
      PH_VER:  phase_next = PH_TYPE;
      PH_TYPE: phase_next = PH_LEN;
      PH_LEN:  phase_next = oversize ? PH_SYNC1 : PH_SEQL;
      PH_SEQL: phase_next = PH_SEQH;
      PH_SEQH: phase_next = (payload_length == 8'd0) ? PH_CRCL : PH_PAY;
      PH_PAY:  phase_next = (count_inc >= payload_length) ? PH_CRCL : PH_PAY;
      PH_CRCL: phase_next = PH_CRCH;
      PH_CRCH: phase_next = PH_SYNC1;
      default: phase_next = (byte_in == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
    endcase
  end

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC1;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  // frame fields; each is written before it is read in a frame
  always_ff @(posedge clk) begin
    if (step) begin
      case (phase)
        PH_SYNC2: begin
          running_crc        <= CRC_INIT;
          payload_count      <= 8'd0;
          first_payload_word <= 16'h0000;
        end
        PH_VER: begin
          version_seen <= byte_in;
          running_crc  <= crc_upd;
        end
        PH_TYPE: begin
          type_seen   <= byte_in;
          running_crc <= crc_upd;
        end
        PH_LEN: begin
          payload_length <= byte_in;
          running_crc    <= crc_upd;
        end
        PH_SEQL: begin
          header_sequence <= {8'h00, byte_in};
          running_crc     <= crc_upd;
        end
        PH_SEQH: begin
          header_sequence[15:8] <= byte_in;
          running_crc           <= crc_upd;
        end
        PH_PAY: begin
          if (payload_count == 8'd0) begin
            first_payload_word[7:0] <= byte_in;
          end else if (payload_count == 8'd1) begin
            first_payload_word[15:8] <= byte_in;
          end
          payload_count <= count_inc;
          running_crc   <= crc_upd;
        end
        PH_CRCL: crc_low_byte <= byte_in;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/cfpr_out_reg.sv
// result register: holds one frame report until the consumer takes it
// depends on cfpr_pkg
module cfpr_out_reg import cfpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     result,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  frame_status,
  output logic [7:0]  frame_type_seen,
  output logic [15:0] frame_sequence,
  output logic [15:0] acked_sequence
);

  result_t held;

  // room for a new item when empty or being drained
  assign free = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign frame_status    = held.status;
  assign frame_type_seen = held.type_seen;
  assign frame_sequence  = held.sequence_no;
  assign acked_sequence  = held.acked;

endmodule

>>> rtl/core/crc16_framed_packet_receiver_core.sv
// Framed packet receiver with CRC-16/CCITT-FALSE check. One received byte is
// taken per cycle unless the input is held: the byte lands in an input register,
// and as it moves on the parser updates its phase, running crc and header
// fields; for the closing CRC byte (or the oversize length byte) a frame report
// (status, type, sequence, acknowledged sequence) is loaded at the same time
// into a result register, which presents it. The input keeps taking one byte every
// cycle while a report waits; only a byte that would close a frame while the
// previous report is still not taken holds the input. Configuration writes
// (index 0 expected version, index 1 acknowledge type) take effect at once and
// belong between frames.
// depends on cfpr_pkg, cfpr_in_reg, cfpr_parser, cfpr_out_reg
module crc16_framed_packet_receiver_core import cfpr_pkg::*; #(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  frame_status,
  output logic [7:0]  frame_type_seen,
  output logic [15:0] frame_sequence,
  output logic [15:0] acked_sequence
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       has_result;
  logic       out_free;
  logic       step;
  result_t    result;

  // the held item moves on unless it closes a frame with no room for its report
  assign step = hold_valid && (!has_result || out_free);

  // input register
  cfpr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .step       (step),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  // parser
  cfpr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_valid (hold_valid),
    .byte_in    (hold_byte),
    .step       (step),
    .has_result (has_result),
    .result     (result)
  );

  // result register
  cfpr_out_reg u_out_reg (
    .clk             (clk),
    .rst             (rst),
    .load            (step && has_result),
    .result          (result),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .frame_status    (frame_status),
    .frame_type_seen (frame_type_seen),
    .frame_sequence  (frame_sequence),
    .acked_sequence  (acked_sequence)
  );

endmodule

>>> verif/cfpr_tb_pkg.sv
// frame report predictor and scoreboard for the framed packet receiver testbench
// depends on cfpr_pkg for the status codes, report layout and framing constants
`timescale 1ns / 1ps
package cfpr_tb_pkg;
  import cfpr_pkg::*;

  // parser position within a frame
  typedef enum logic [3:0] {
    RX_HUNT_C3,
    RX_HUNT_3C,
    RX_VER,
    RX_TYPE,
    RX_LEN,
    RX_SEQ_LO,
    RX_SEQ_HI,
    RX_PAYLOAD,
    RX_CRC_LO,
    RX_CRC_HI
  } rx_phase_t;

  // crc-16/ccitt-false, one input bit at a time, msb first
  function automatic logic [15:0] crc16_feed(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  class frame_scoreboard;
    // register copies
    logic [7:0]  want_version;
    logic [7:0]  want_ack_type;
    // parser copy
    rx_phase_t   phase;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo;
    logic [7:0]  ver;
    logic [7:0]  typ;
    logic [7:0]  len;
    logic [15:0] seq_no;
    logic [7:0]  count;
    logic [15:0] first_word;
    // reports still owed by the block
    result_t     pending[$];
    int          n_inputs;
    int          n_predicted;
    int          n_checked;
    int          n_errors;
    int          by_status[4];

    function new();
      want_version = 8'd1;
      want_ack_type = 8'd2;
      phase = RX_HUNT_C3;
      ver = 8'h00;
      typ = 8'h00;
      first_word = 16'h0000;
      end_frame();
      n_inputs = 0;
      n_predicted = 0;
      n_checked = 0;
      n_errors = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function void set_register(logic idx, logic [7:0] v);
      if (idx == CFG_EXPECTED_VERSION) begin
        want_version = v;
      end else begin
        want_ack_type = v;
      end
    endfunction

    // back to hunting, version and type are kept
    function void end_frame();
      phase = RX_HUNT_C3;
      count = 8'h00;
      len = 8'h00;
      seq_no = 16'h0000;
      crc_lo = 8'h00;
      crc_acc = 16'h0000;
    endfunction

    function void push_report(status_t st, logic [15:0] sq);
      result_t r;
      r.status = st;
      r.type_seen = typ;
      r.sequence_no = sq;
      r.acked = (st == ST_ACK) ? first_word : 16'h0000;
      pending.push_back(r);
      n_predicted++;
      by_status[int'(st)]++;
      end_frame();
    endfunction

    // one accepted input item
    function void note_input(logic [7:0] b);
      logic [15:0] got_crc;
      n_inputs++;
      case (phase)
        RX_HUNT_3C: begin
          if (b == SYNC_SECOND) begin
            crc_acc = CRC_INIT;
            count = 8'h00;
            first_word = 16'h0000;
            phase = RX_VER;
          end else begin
            phase = (b == SYNC_FIRST) ? RX_HUNT_3C : RX_HUNT_C3;
          end
        end
        RX_VER: begin
          ver = b;
          crc_acc = crc16_feed(crc_acc, b);
          phase = RX_TYPE;
        end
        RX_TYPE: begin
          typ = b;
          crc_acc = crc16_feed(crc_acc, b);
          phase = RX_LEN;
        end
        RX_LEN: begin
          len = b;
          crc_acc = crc16_feed(crc_acc, b);
          if (b > DEF_MAX_PAYLOAD) begin
            push_report(ST_OVERSIZE, 16'h0000);
          end else begin
            phase = RX_SEQ_LO;
          end
        end
        RX_SEQ_LO: begin
          seq_no = {8'h00, b};
          crc_acc = crc16_feed(crc_acc, b);
          phase = RX_SEQ_HI;
        end
        RX_SEQ_HI: begin
          seq_no[15:8] = b;
          crc_acc = crc16_feed(crc_acc, b);
          phase = (len == 8'h00) ? RX_CRC_LO : RX_PAYLOAD;
        end
        RX_PAYLOAD: begin
          if (count == 8'd0) begin
            first_word[7:0] = b;
          end else if (count == 8'd1) begin
            first_word[15:8] = b;
          end
          count = count + 8'd1;
          crc_acc = crc16_feed(crc_acc, b);
          if (count >= len) phase = RX_CRC_LO;
        end
        RX_CRC_LO: begin
          crc_lo = b;
          phase = RX_CRC_HI;
        end
        RX_CRC_HI: begin
          got_crc = {b, crc_lo};
          if (got_crc != crc_acc) begin
            push_report(ST_CRC_BAD, seq_no);
          end else if (ver == want_version && typ == want_ack_type && len == 8'd2) begin
            push_report(ST_ACK, seq_no);
          end else begin
            push_report(ST_NOT_ACK, seq_no);
          end
        end
        default: begin
          phase = (b == SYNC_FIRST) ? RX_HUNT_3C : RX_HUNT_C3;
        end
      endcase
    endfunction

    task report(string what);
      n_errors++;
      if (n_errors <= 100) $display("mismatch: %s", what);
    endtask

    // one accepted frame report against the oldest prediction
    task check_result(logic [1:0] st, logic [7:0] ty, logic [15:0] sq, logic [15:0] ak);
      result_t w;
      n_checked++;
      if (pending.size() == 0) begin
        report($sformatf("report %0d not predicted: status %0d type %h seq %h ack %h",
                         n_checked, st, ty, sq, ak));
      end else begin
        w = pending.pop_front();
        if (st !== w.status)
          report($sformatf("report %0d status %0d, want %0d", n_checked, st, w.status));
        if (ty !== w.type_seen)
          report($sformatf("report %0d type %h, want %h", n_checked, ty, w.type_seen));
        if (sq !== w.sequence_no)
          report($sformatf("report %0d seq %h, want %h", n_checked, sq, w.sequence_no));
        if (ak !== w.acked)
          report($sformatf("report %0d acked %h, want %h", n_checked, ak, w.acked));
      end
    endtask

    // anything still owed after the wait is lost
    task flush_leftovers();
      result_t w;
      while (pending.size() != 0) begin
        w = pending.pop_front();
        report($sformatf("report never came: status %0d type %h seq %h",
                         w.status, w.type_seen, w.sequence_no));
      end
    endtask
  endclass

endpackage

>>> verif/tb_top.sv
// top of the framed packet receiver testbench: clock, reset, byte sender, report taker
// depends on cfpr_pkg, cfpr_tb_pkg and crc16_framed_packet_receiver_core
`timescale 1ns / 1ps
module tb_top;
  import cfpr_pkg::*;
  import cfpr_tb_pkg::*;

  localparam int RUN_LIMIT_NS  = 4_000_000;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 160;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  frame_status;
  logic [7:0]  frame_type_seen;
  logic [15:0] frame_sequence;
  logic [15:0] acked_sequence;

  frame_scoreboard sb;
  logic [7:0]      tx_bytes[$];
  logic            no_idle;
  int              hold_requests;
  int              bytes_sent;
  int              cfg_writes;

  crc16_framed_packet_receiver_core u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .frame_status    (frame_status),
    .frame_type_seen (frame_type_seen),
    .frame_sequence  (frame_sequence),
    .acked_sequence  (acked_sequence)
  );

  always #4 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // append one frame to the send queue, crc_xor spoils the checksum
  function automatic void build_frame(logic [7:0] ver, logic [7:0] typ, logic [7:0] len,
                                      logic [15:0] seq_no, logic [15:0] first,
                                      logic [15:0] crc_xor);
    logic [15:0] c;
    logic [7:0]  pb;
    tx_bytes.push_back(SYNC_FIRST);
    tx_bytes.push_back(SYNC_SECOND);
    c = CRC_INIT;
    tx_bytes.push_back(ver);
    c = crc16_feed(c, ver);
    tx_bytes.push_back(typ);
    c = crc16_feed(c, typ);
    tx_bytes.push_back(len);
    c = crc16_feed(c, len);
    if (len > DEF_MAX_PAYLOAD) return;
    tx_bytes.push_back(seq_no[7:0]);
    c = crc16_feed(c, seq_no[7:0]);
    tx_bytes.push_back(seq_no[15:8]);
    c = crc16_feed(c, seq_no[15:8]);
    for (int i = 0; i < int'(len); i++) begin
      pb = (i == 0) ? first[7:0] : (i == 1) ? first[15:8] : 8'($urandom);
      tx_bytes.push_back(pb);
      c = crc16_feed(c, pb);
    end
    c = c ^ crc_xor;
    tx_bytes.push_back(c[7:0]);
    tx_bytes.push_back(c[15:8]);
  endfunction

  // offer one item and wait for it to be taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b);
    bytes_sent++;
  endtask

  task automatic send_tx_bytes();
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
  endtask

  // wait for every owed report, then let the pipeline settle
  task automatic drain_reports();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flush_leftovers();
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_register(idx, v);
    cfg_writes++;
  endtask

  task automatic set_regs(input logic [7:0] ver, input logic [7:0] ack_type);
    write_reg(CFG_EXPECTED_VERSION, ver);
    write_reg(CFG_ACK_TYPE_CODE, ack_type);
  endtask

  // one random frame, mostly well formed, some noise, bad crcs and cut-offs
  task automatic send_random_frame();
    logic [7:0]  ver;
    logic [7:0]  typ;
    logic [7:0]  len;
    logic [15:0] crc_xor;
    int          kind;
    int          cut;
    ver = $urandom_range(0, 1) ? sb.want_version : 8'($urandom);
    typ = $urandom_range(0, 1) ? sb.want_ack_type : 8'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 40) len = 8'd2;
    else if (kind < 84) len = 8'($urandom_range(0, 6));
    else if (kind < 88) len = 8'(DEF_MAX_PAYLOAD - $urandom_range(0, 1));
    else len = 8'($urandom_range(DEF_MAX_PAYLOAD + 1, 255));
    crc_xor = ($urandom_range(0, 99) < 12) ? 16'(1 << $urandom_range(0, 15)) : 16'h0000;
    // line noise before the frame, often repeated first sync bytes
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3))
        tx_bytes.push_back($urandom_range(0, 1) ? SYNC_FIRST : 8'($urandom));
    end
    build_frame(ver, typ, len, 16'($urandom), 16'($urandom), crc_xor);
    // broken frame: cut short, the next frame runs into it
    if ($urandom_range(0, 99) < 8) begin
      cut = $urandom_range(1, tx_bytes.size() - 1);
      while (tx_bytes.size() > cut) void'(tx_bytes.pop_back());
    end
    send_tx_bytes();
  endtask

  task automatic random_phase(input int n_bytes, input int min_reports);
    int start_bytes;
    int start_reports;
    start_bytes = bytes_sent;
    start_reports = sb.n_predicted;
    while (bytes_sent - start_bytes < n_bytes || sb.n_predicted - start_reports < min_reports)
      send_random_frame();
  endtask

  // report taker with random stalls and the odd long hold-off
  initial begin
    int stall;
    int served;
    stall = 0;
    served = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != served) begin
        served = hold_requests;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // check every report taken
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(frame_status, frame_type_seen, frame_sequence, acked_sequence);
  end

  // stimulus
  initial begin
    sb = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_EXPECTED_VERSION;
    cfg_data = 8'h00;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    no_idle = 1'b0;
    hold_requests = 0;
    bytes_sent = 0;
    cfg_writes = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: noise, repeated first sync byte and a valid ack with reset registers
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(SYNC_FIRST);
    build_frame(8'd1, 8'd2, 8'd2, 16'hFFFF, 16'h00FF, 16'h0000);
    // length just above capacity, dropped after the length byte
    build_frame(8'h00, 8'hFF, 8'(DEF_MAX_PAYLOAD + 1), 16'h0000, 16'h0000, 16'h0000);
    // zero length straight to the checksum, which is spoilt
    build_frame(8'd1, 8'd2, 8'd0, 16'h8001, 16'h0000, 16'h0001);
    send_tx_bytes();
    drain_reports();

    // register extremes one way
    set_regs(8'h00, 8'hFF);
    random_phase(80, 10);
    drain_reports();

    // the other way, with a long output hold-off while frames keep coming
    set_regs(8'hFF, 8'h00);
    hold_requests++;
    repeat (8) begin
      build_frame(8'($urandom), 8'($urandom), 8'($urandom_range(DEF_MAX_PAYLOAD + 1, 255)),
                  16'h0000, 16'h0000, 16'h0000);
      send_tx_bytes();
    end
    random_phase(80, 10);
    drain_reports();

    // random registers, back to back with no idling
    set_regs(8'($urandom), 8'($urandom));
    no_idle = 1'b1;
    random_phase(80, 10);
    drain_reports();
    no_idle = 1'b0;

    // reset values again
    set_regs(8'd1, 8'd2);
    random_phase(80, 10);
    drain_reports();

    $display("covered %0d bytes, %0d reports: ack %0d, crc bad %0d, not ack %0d, oversize %0d",
             sb.n_inputs, sb.n_checked, sb.by_status[0], sb.by_status[1],
             sb.by_status[2], sb.by_status[3]);
    $display("%0d register writes, %0d long hold-offs, %0d mismatches",
             cfg_writes, hold_requests, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("[crc16_framed_packet_receiver_core] OK");
    end else begin
      $display("[crc16_framed_packet_receiver_core] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("timed out");
    $display("[crc16_framed_packet_receiver_core] ERROR");
    $finish;
  end

endmodule
